/* hdl/assert_macros.svh */
// assertion macros used by the port-level checks in hdl/rts_checker.sv
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define RTS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define RTS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/rts_pkg.sv */
// types, hash constants and controller/datapath command words of the selector
// no dependencies
`timescale 1ns / 1ps

package rts_pkg;

    localparam int ID_W   = 16;
    localparam int REM_W  = 14;
    localparam int PROD_W = 38;
    localparam int OPA_W  = 16;
    localparam int OPB_W  = 22;

    // remainder unit: bits consumed per step and steps per pass
    localparam int RED_BITS  = 8;
    localparam int RED_STEPS = 5;
    localparam int DIV_W     = RED_BITS * RED_STEPS;
    localparam int STEP_W    = $clog2(RED_STEPS);

    // hash constants
    localparam int HASH_OFS_A = 30000;
    localparam int HASH_MUL_A = 17;
    localparam int MOD_A      = 1432;
    localparam int MOD_B      = 191;
    localparam int HASH_MUL_C = 54;
    localparam int HASH_OFS_C = 34422;
    localparam int MOD_C      = 12487;

    // 2^64 reduced by MOD_A and by MOD_C, used to fold back a negative value
    localparam int WRAP_A = 840;
    localparam int WRAP_C = 5542;

    typedef enum logic [1:0] {
        PASS_HASH,
        PASS_KEY,
        PASS_SCORE
    } t_pass;

    typedef struct packed {
        logic [ID_W-1:0] query_key;
        logic [ID_W-1:0] file_segment;
        logic [ID_W-1:0] candidate_id;
        logic            last_candidate;
    } t_item_word;

    typedef struct packed {
        logic [ID_W-1:0] first_choice;
        logic [ID_W-1:0] second_choice;
        logic [ID_W-1:0] third_choice;
    } t_result_word;

    typedef logic [ID_W-1:0] t_cfg_word;

    typedef struct packed {
        logic  load;
        logic  mul_en;
        logic  sum_en;
        logic  mod_load;
        logic  mod_step;
        logic  fix_en;
        logic  insert;
        logic  emit;
        t_pass pass;
    } t_dp_cmd;

    typedef struct packed {
        logic own_hit;
        logic last;
        logic out_busy;
    } t_dp_status;

endpackage

/* hdl/rts_if.sv */
// handshake channels of the selector: candidate words, result words, config writes
// depends on rts_pkg
`timescale 1ns / 1ps

interface rts_item_if;
    import rts_pkg::*;
    logic       valid;
    logic       ready;
    t_item_word data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface rts_result_if;
    import rts_pkg::*;
    logic         valid;
    logic         ready;
    t_result_word data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface rts_cfg_if;
    import rts_pkg::*;
    logic      valid;
    logic      ready;
    t_cfg_word data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* hdl/rts_ctrl.sv */
// sequencer of the selector: walks one candidate through the three hash passes
// depends on rts_pkg
`timescale 1ns / 1ps

module rts_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_item_valid,
    output logic                o_item_ready,
    input  rts_pkg::t_dp_status i_status,
    output rts_pkg::t_dp_cmd    o_cmd
);
    import rts_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_SUM,
        S_LOAD,
        S_RED,
        S_FIX,
        S_INSERT,
        S_FINISH
    } t_state;

    t_state            r_state;
    t_pass             r_pass;
    logic [STEP_W-1:0] r_step;

    assign o_item_ready = (r_state == S_IDLE);

    always_comb begin
        o_cmd      = '0;
        o_cmd.pass = r_pass;
        unique case (r_state)
            S_IDLE:   o_cmd.load = i_item_valid;
            S_MUL:    o_cmd.mul_en = 1'b1;
            S_SUM:    o_cmd.sum_en = 1'b1;
            S_LOAD:   o_cmd.mod_load = 1'b1;
            S_RED:    o_cmd.mod_step = 1'b1;
            S_FIX:    o_cmd.fix_en = 1'b1;
            S_INSERT: o_cmd.insert = 1'b1;
            S_FINISH: o_cmd.emit = i_status.last && !i_status.out_busy;
            default:  o_cmd = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pass  <= PASS_HASH;
            r_step  <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_item_valid) begin
                        r_state <= S_MUL;
                        r_pass  <= PASS_HASH;
                    end
                end
                S_MUL: begin
                    if (r_pass == PASS_HASH && i_status.own_hit) begin
                        r_state <= S_FINISH;
                    end else if (r_pass == PASS_SCORE) begin
                        r_state <= S_SUM;
                    end else begin
                        r_state <= S_LOAD;
                    end
                end
                S_SUM: begin
                    r_state <= S_LOAD;
                end
                S_LOAD: begin
                    r_step  <= '0;
                    r_state <= S_RED;
                end
                S_RED: begin
                    if (r_step == STEP_W'(RED_STEPS - 1)) begin
                        r_state <= S_FIX;
                    end else begin
                        r_step <= r_step + 1'b1;
                    end
                end
                S_FIX: begin
                    unique case (r_pass)
                        PASS_HASH: begin
                            r_pass  <= PASS_KEY;
                            r_state <= S_MUL;
                        end
                        PASS_KEY: begin
                            r_pass  <= PASS_SCORE;
                            r_state <= S_MUL;
                        end
                        PASS_SCORE: r_state <= S_INSERT;
                        default:    r_state <= S_IDLE;
                    endcase
                end
                S_INSERT: begin
                    r_state <= S_FINISH;
                end
                S_FINISH: begin
                    if (!i_status.last || !i_status.out_busy) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

/* hdl/rts_datapath.sv */
// datapath of the selector: shared multiplier, remainder unit, ranking and result register
// depends on rts_pkg
`timescale 1ns / 1ps

module rts_datapath (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  rts_pkg::t_item_word   i_item_data,
    input  logic                  i_cfg_valid,
    input  rts_pkg::t_cfg_word    i_cfg_data,
    input  rts_pkg::t_dp_cmd      i_cmd,
    output rts_pkg::t_dp_status   o_status,
    output logic                  o_out_valid,
    output rts_pkg::t_result_word o_out_data,
    input  logic                  i_out_ready
);
    import rts_pkg::*;

    logic [ID_W-1:0]   r_own_id;
    logic [ID_W-1:0]   r_key;
    logic [ID_W-1:0]   r_seg;
    logic [ID_W-1:0]   r_id;
    logic              r_last;
    logic [PROD_W-1:0] r_prod;
    logic [DIV_W-1:0]  r_div;
    logic [REM_W-1:0]  r_rem;
    logic              r_neg;
    logic [REM_W-1:0]  r_m;
    logic [ID_W-1:0]   r_ids [3];
    logic [REM_W-1:0]  r_scores [3];
    logic              r_out_valid;
    t_result_word      r_out_data;

    logic [OPA_W-1:0]  w_opa;
    logic [OPB_W-1:0]  w_opb;
    logic [PROD_W-1:0] w_prod;
    logic [PROD_W-1:0] w_load_val;
    logic              w_load_neg;
    logic [REM_W-1:0]  w_mod;
    logic [REM_W-1:0]  w_wrap;
    logic [REM_W:0]    w_acc;
    logic [REM_W-1:0]  w_fix;
    logic [17:0]       w_seg3;

    // multiplier operands per pass
    always_comb begin
        unique case (i_cmd.pass)
            PASS_HASH: begin
                if (r_id >= ID_W'(HASH_OFS_A)) begin
                    w_opa = r_id - ID_W'(HASH_OFS_A);
                end else begin
                    w_opa = ID_W'(HASH_OFS_A) - r_id;
                end
                w_opb = OPB_W'(r_seg) * OPB_W'(HASH_MUL_A);
            end
            PASS_KEY: begin
                w_opa = r_key;
                w_opb = OPB_W'(r_m);
            end
            PASS_SCORE: begin
                w_opa = OPA_W'(r_m);
                w_opb = OPB_W'(r_seg) * OPB_W'(HASH_MUL_C);
            end
            default: begin
                w_opa = '0;
                w_opb = '0;
            end
        endcase
    end

    assign w_prod = PROD_W'(w_opa) * PROD_W'(w_opb);
    assign w_seg3 = 18'({r_seg, 1'b0}) + 18'(r_seg);

    // remainder unit operand, sign and modulus per pass
    always_comb begin
        w_load_val = r_prod;
        w_load_neg = 1'b0;
        unique case (i_cmd.pass)
            PASS_HASH: begin
                w_mod      = REM_W'(MOD_A);
                w_wrap     = REM_W'(WRAP_A);
                w_load_neg = (r_id < ID_W'(HASH_OFS_A)) && (r_seg != '0);
            end
            PASS_KEY: begin
                w_mod  = REM_W'(MOD_B);
                w_wrap = '0;
            end
            PASS_SCORE: begin
                w_mod  = REM_W'(MOD_C);
                w_wrap = REM_W'(WRAP_C);
                if (r_prod < PROD_W'(HASH_OFS_C)) begin
                    w_load_val = PROD_W'(HASH_OFS_C) - r_prod;
                    w_load_neg = 1'b1;
                end else begin
                    w_load_val = r_prod - PROD_W'(HASH_OFS_C);
                end
            end
            default: begin
                w_mod  = REM_W'(MOD_C);
                w_wrap = '0;
            end
        endcase
    end

    // restoring remainder, several bits per step
    always_comb begin
        w_acc = {1'b0, r_rem};
        for (int b = 0; b < RED_BITS; b++) begin
            w_acc = {w_acc[REM_W-1:0], r_div[DIV_W-1-b]};
            if (w_acc >= {1'b0, w_mod}) begin
                w_acc = w_acc - {1'b0, w_mod};
            end
        end
    end

    // fold a negative value back through 2^64
    always_comb begin
        if (!r_neg) begin
            w_fix = r_rem;
        end else if (r_rem <= w_wrap) begin
            w_fix = w_wrap - r_rem;
        end else begin
            w_fix = w_wrap + (w_mod - r_rem);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_id <= '0;
        end else if (i_cfg_valid) begin
            r_own_id <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_key  <= i_item_data.query_key;
            r_seg  <= i_item_data.file_segment;
            r_id   <= i_item_data.candidate_id;
            r_last <= i_item_data.last_candidate;
        end
        if (i_cmd.mul_en) begin
            r_prod <= w_prod;
        end else if (i_cmd.sum_en) begin
            r_prod <= r_prod + PROD_W'(r_id) + PROD_W'(w_seg3);
        end
        if (i_cmd.mod_load) begin
            r_div <= DIV_W'(w_load_val);
            r_rem <= '0;
            r_neg <= w_load_neg;
        end else if (i_cmd.mod_step) begin
            r_div <= r_div << RED_BITS;
            r_rem <= w_acc[REM_W-1:0];
        end
        if (i_cmd.fix_en) begin
            r_m <= w_fix;
        end
        if (i_cmd.emit) begin
            r_out_data.first_choice  <= r_ids[0];
            r_out_data.second_choice <= r_ids[1];
            r_out_data.third_choice  <= r_ids[2];
        end
    end

    // ranking of the three best candidates and result handshake
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                r_ids[i]    <= '0;
                r_scores[i] <= '0;
            end
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.emit) begin
                for (int i = 0; i < 3; i++) begin
                    r_ids[i]    <= '0;
                    r_scores[i] <= '0;
                end
            end else if (i_cmd.insert) begin
                priority if (r_m > r_scores[0]) begin
                    r_ids[2]    <= r_ids[1];
                    r_scores[2] <= r_scores[1];
                    r_ids[1]    <= r_ids[0];
                    r_scores[1] <= r_scores[0];
                    r_ids[0]    <= r_id;
                    r_scores[0] <= r_m;
                end else if (r_m > r_scores[1]) begin
                    r_ids[2]    <= r_ids[1];
                    r_scores[2] <= r_scores[1];
                    r_ids[1]    <= r_id;
                    r_scores[1] <= r_m;
                end else if (r_m > r_scores[2]) begin
                    r_ids[2]    <= r_id;
                    r_scores[2] <= r_m;
                end else begin
                    // not above any kept score, ranking unchanged
                end
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_status.own_hit  = (r_id == r_own_id);
    assign o_status.last     = r_last;
    assign o_status.out_busy = r_out_valid && !i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

/* hdl/rendezvous_top3_selector.sv */
// Rendezvous top-three selector. Each candidate word is scored by a fixed hash of node id,
// file key and segment; a candidate equal to the configured own id is skipped. The three
// best ids are kept (strict greater-than, so ties keep the earlier node and a zero score is
// never kept) and sent as one result word on the candidate marked last, after which the
// ranking clears. Each candidate word is finished before the next is accepted, an own-id
// word after its first multiply; the work is three passes through one shared 16x22 multiplier and one
// remainder unit that takes 8 bits a cycle in each pass. A finished result waits
// in an output register while the next candidates are taken; a last candidate waits for it
// to drain. The own-id register is written through the config channel, always ready.
// depends on rts_pkg, rts_if, rts_ctrl, rts_datapath
`timescale 1ns / 1ps

module rendezvous_top3_selector (
    input logic           i_clk,
    input logic           i_rst_n,
    rts_item_if.sink      i_item,
    rts_result_if.source  o_result,
    rts_cfg_if.sink       i_cfg
);
    import rts_pkg::*;

    t_dp_cmd    w_cmd;
    t_dp_status w_status;
    logic       w_item_ready;

    assign i_item.ready = w_item_ready;
    assign i_cfg.ready  = 1'b1;

    rts_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (i_item.valid),
        .o_item_ready (w_item_ready),
        .i_status     (w_status),
        .o_cmd        (w_cmd)
    );

    rts_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item_data (i_item.data),
        .i_cfg_valid (i_cfg.valid),
        .i_cfg_data  (i_cfg.data),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_out_valid (o_result.valid),
        .o_out_data  (o_result.data),
        .i_out_ready (o_result.ready)
    );

endmodule

/* hdl/rts_checker.sv */
// port-level checks of the selector and their binding to the top level
// depends on rts_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rts_props (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_item_valid,
    input logic                  i_item_ready,
    input logic                  i_out_valid,
    input logic                  i_out_ready,
    input rts_pkg::t_result_word i_out_data
);
    import rts_pkg::*;

    logic w_out_stall;
    logic w_item_take;

    assign w_out_stall = i_out_valid && !i_out_ready;
    assign w_item_take = i_item_valid && i_item_ready;

    `RTS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, w_out_stall, i_out_valid, "result dropped")
    `RTS_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, w_out_stall, $stable(i_out_data), "result moved")
    `RTS_ASSERT_NEXT(a_busy_take, i_clk, i_rst_n, w_item_take, !i_item_ready, "ready while busy")
    `RTS_ASSERT_NEXT(a_no_early, i_clk, i_rst_n, w_item_take, !$rose(i_out_valid), "early result")

endmodule

bind rendezvous_top3_selector rts_props u_props (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_item_valid (i_item.valid),
    .i_item_ready (i_item.ready),
    .i_out_valid  (o_result.valid),
    .i_out_ready  (o_result.ready),
    .i_out_data   (o_result.data)
);

/* test/rts_checker.sv */
// checker for the rendezvous top-three selector: watches the candidate, result and own-id
// channels, predicts each result word from its own hash and ranking, and counts mismatches
// depends on rts_pkg and rts_if
`timescale 1ns / 1ps

module rts_checker (
    input  logic         i_clk,
    input  logic         i_rst_n,
    rts_item_if          i_item,
    rts_result_if        i_result,
    rts_cfg_if           i_cfg,
    output int           o_errors,
    output int           o_pending
);
    import rts_pkg::*;

    logic [ID_W-1:0]  own_id;
    logic [ID_W-1:0]  kept_id [3];
    logic [REM_W-1:0] kept_score [3];
    t_result_word     expected_choices [$];
    int               error_total = 0;

    function automatic logic [REM_W-1:0] placement_score(input logic [ID_W-1:0] key,
                                                          input logic [ID_W-1:0] seg,
                                                          input logic [ID_W-1:0] node);
        logic [63:0] k;
        logic [63:0] s;
        logic [63:0] n;
        logic [63:0] m;
        k = 64'(key);
        s = 64'(seg);
        n = 64'(node);
        m = (n - 64'(HASH_OFS_A)) * 64'(HASH_MUL_A) * s;
        m = m % 64'(MOD_A);
        m = (m * k) % 64'(MOD_B);
        m = m * 64'(HASH_MUL_C) * s;
        m = m + (n - 64'(HASH_OFS_C));
        m = m + s * 64'd3;
        m = m % 64'(MOD_C);
        return m[REM_W-1:0];
    endfunction

    task automatic rank_candidate(input logic [ID_W-1:0] id, input logic [REM_W-1:0] sc);
        if (sc > kept_score[0]) begin
            kept_id[2] = kept_id[1];
            kept_score[2] = kept_score[1];
            kept_id[1] = kept_id[0];
            kept_score[1] = kept_score[0];
            kept_id[0] = id;
            kept_score[0] = sc;
        end else if (sc > kept_score[1]) begin
            kept_id[2] = kept_id[1];
            kept_score[2] = kept_score[1];
            kept_id[1] = id;
            kept_score[1] = sc;
        end else if (sc > kept_score[2]) begin
            kept_id[2] = id;
            kept_score[2] = sc;
        end
    endtask

    task automatic clear_ranking();
        for (int i = 0; i < 3; i++) begin
            kept_id[i] = '0;
            kept_score[i] = '0;
        end
    endtask

    task automatic compare_choices(input t_result_word got);
        t_result_word want;
        if (expected_choices.size() == 0) begin
            $error("result word with no expectation pending: %0d %0d %0d",
                   got.first_choice, got.second_choice, got.third_choice);
            error_total++;
            return;
        end
        want = expected_choices.pop_front();
        if (got.first_choice !== want.first_choice) begin
            $error("first_choice: expected %0d, actual %0d", want.first_choice, got.first_choice);
            error_total++;
        end
        if (got.second_choice !== want.second_choice) begin
            $error("second_choice: expected %0d, actual %0d",
                   want.second_choice, got.second_choice);
            error_total++;
        end
        if (got.third_choice !== want.third_choice) begin
            $error("third_choice: expected %0d, actual %0d", want.third_choice, got.third_choice);
            error_total++;
        end
    endtask

    always @(posedge i_clk) begin
        t_item_word   w;
        t_result_word r;
        if (!i_rst_n) begin
            own_id = '0;
            clear_ranking();
            expected_choices.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready)
                own_id = i_cfg.data;
            if (i_result.valid && i_result.ready)
                compare_choices(i_result.data);
            if (i_item.valid && i_item.ready) begin
                w = i_item.data;
                if (w.candidate_id != own_id)
                    rank_candidate(w.candidate_id,
                                   placement_score(w.query_key, w.file_segment, w.candidate_id));
                if (w.last_candidate) begin
                    r.first_choice = kept_id[0];
                    r.second_choice = kept_id[1];
                    r.third_choice = kept_id[2];
                    expected_choices.push_back(r);
                    clear_ranking();
                end
            end
        end
        o_errors <= error_total;
        o_pending <= expected_choices.size();
    end

endmodule

/* test/testbench.sv */
// top of the selector testbench: clock, reset, candidate and own-id stimulus, result-side
// stalls and the final verdict; prediction and comparison live in rts_checker
// depends on rts_pkg, rts_if, rts_checker and rendezvous_top3_selector
`timescale 1ns / 1ps

module testbench;
    import rts_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 60;
    localparam int HOLD_CYCLES  = 1500;
    localparam int PHASE_ITEMS  = 120;

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   error_count;
    int   pending_count;
    int   cycle_count = 0;
    int   send_idle_pct;
    int   recv_stall_pct;
    int   hold_requests = 0;
    int   hold_served = 0;
    int   hold_left = 0;
    logic [ID_W-1:0] cur_own = '0;

    rts_item_if   cand_bus ();
    rts_result_if choice_bus ();
    rts_cfg_if    own_bus ();

    rendezvous_top3_selector u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (cand_bus),
        .o_result (choice_bus),
        .i_cfg    (own_bus)
    );

    rts_checker u_checker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_item    (cand_bus),
        .i_result  (choice_bus),
        .i_cfg     (own_bus),
        .o_errors  (error_count),
        .o_pending (pending_count)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("testbench: errors");
            $finish;
        end
    end

    // result side: random stalls plus one long hold-off in the first random phase
    always @(posedge i_clk) begin
        if (hold_requests != hold_served) begin
            hold_served = hold_requests;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            choice_bus.ready <= 1'b0;
        end else begin
            choice_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic t_item_word cand_word(input logic [ID_W-1:0] key,
                                             input logic [ID_W-1:0] seg,
                                             input logic [ID_W-1:0] id,
                                             input logic last);
        t_item_word w;
        w.query_key = key;
        w.file_segment = seg;
        w.candidate_id = id;
        w.last_candidate = last;
        return w;
    endfunction

    task automatic send_word(input t_item_word w);
        while ($urandom_range(99) < send_idle_pct) begin
            cand_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        cand_bus.valid <= 1'b1;
        cand_bus.data <= w;
        do @(posedge i_clk); while (!cand_bus.ready);
    endtask

    task automatic settle();
        cand_bus.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_own_id(input t_cfg_word v);
        own_bus.valid <= 1'b1;
        own_bus.data <= v;
        do @(posedge i_clk); while (!own_bus.ready);
        own_bus.valid <= 1'b0;
        cur_own = v;
    endtask

    task automatic random_query(output int len);
        logic [ID_W-1:0] key;
        logic [ID_W-1:0] seg;
        logic [ID_W-1:0] id;
        t_item_word      w;
        int              pick;
        pick = $urandom_range(99);
        if (pick < 80)
            len = $urandom_range(1, 4);
        else if (pick < 97)
            len = $urandom_range(5, 8);
        else
            len = 14;
        key = ID_W'($urandom());
        pick = $urandom_range(99);
        seg = (pick < 10) ? '0 : (pick < 18) ? '1 : ID_W'($urandom());
        for (int i = 0; i < len; i++) begin
            pick = $urandom_range(99);
            if (pick < 10)
                id = cur_own;
            else if (pick < 18)
                case ($urandom_range(3))
                    0: id = 16'd34422;
                    1: id = 16'd46909;
                    2: id = 16'd30000;
                    default: id = 16'd34423;
                endcase
            else
                id = ID_W'($urandom());
            w = cand_word(key, seg, id, i == len - 1);
            // occasional query whose key or segment drifts between candidates
            if ($urandom_range(99) < 5)
                w.query_key = ID_W'($urandom());
            if ($urandom_range(99) < 5)
                w.file_segment = ID_W'($urandom());
            send_word(w);
        end
    endtask

    initial begin
        int sent;
        int len;
        i_rst_n = 1'b0;
        cand_bus.valid = 1'b0;
        cand_bus.data = '0;
        own_bus.valid = 1'b0;
        own_bus.data = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part, no idling
        write_own_id(16'd0);
        send_word(cand_word(16'd0, 16'd0, 16'd0, 1'b1));
        send_word(cand_word(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1));
        // segment zero: score is the id offset, exercises every insertion slot
        send_word(cand_word(16'd9, 16'd0, 16'd34425, 1'b0));
        send_word(cand_word(16'd9, 16'd0, 16'd34423, 1'b0));
        send_word(cand_word(16'd9, 16'd0, 16'd34427, 1'b0));
        send_word(cand_word(16'd9, 16'd0, 16'd34424, 1'b0));
        send_word(cand_word(16'd9, 16'd0, 16'd34426, 1'b1));
        // zero scores
        send_word(cand_word(16'd5, 16'd0, 16'd34422, 1'b0));
        send_word(cand_word(16'd5, 16'd0, 16'd46909, 1'b1));
        // equal scores
        send_word(cand_word(16'd5, 16'd0, 16'd34423, 1'b0));
        send_word(cand_word(16'd5, 16'd0, 16'd46910, 1'b0));
        send_word(cand_word(16'd5, 16'd0, 16'd59397, 1'b1));
        // key and segment change inside one query
        send_word(cand_word(16'd1, 16'd2, 16'd100, 1'b0));
        send_word(cand_word(16'd300, 16'd4000, 16'd65000, 1'b0));
        send_word(cand_word(16'hFFFF, 16'd0, 16'd0, 1'b0));
        send_word(cand_word(16'd12345, 16'd54321, 16'd777, 1'b1));
        send_word(cand_word(16'd0, 16'hFFFF, 16'd30000, 1'b1));
        settle();
        write_own_id(16'hFFFF);
        send_word(cand_word(16'd7, 16'd9, 16'hFFFF, 1'b0));
        send_word(cand_word(16'd7, 16'd9, 16'd1, 1'b1));
        send_word(cand_word(16'd7, 16'd9, 16'hFFFF, 1'b1));
        settle();

        // random phases, each with its own idling mix and own id
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 71; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 71; end
                default: begin send_idle_pct = 21; recv_stall_pct = 21; end
            endcase
            case (phase)
                0: write_own_id(ID_W'($urandom()));
                1: write_own_id(16'd34423);
                2: write_own_id(ID_W'($urandom()));
                default: write_own_id(16'd0);
            endcase
            if (phase == 0)
                hold_requests = hold_requests + 1;
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                random_query(len);
                sent = sent + len;
            end
            settle();
        end

        if (error_count == 0 && pending_count == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
